[hdl/lfsa_pkg.sv]
`default_nettype none
package lfsa_pkg;
	localparam int SlotCountDef = 256;

	typedef enum logic [1:0] {
		OP_CREATE  = 2'd0,
		OP_DESTROY = 2'd1,
		OP_LOOKUP  = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_MAPPED  = 2'd1,
		ST_MISSING = 2'd2,
		ST_FULL    = 2'd3
	} status_t;
endpackage
`default_nettype wire

[hdl/lfsa_key_search.sv]
`default_nettype none
// Sequential key match: one slot compared per cycle against the key store.
module lfsa_key_search import lfsa_pkg::*; #(
	parameter int SLOT_COUNT = SlotCountDef,
	localparam int IW = $clog2(SLOT_COUNT)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          go,
	input  wire logic [63:0]   key,
	input  wire logic          wr_en,
	input  wire logic [IW-1:0] wr_idx,
	input  wire logic [63:0]   wr_key,
	input  wire logic [SLOT_COUNT-1:0] in_use,
	output logic               done,
	output logic               found,
	output logic [IW-1:0]      hit_idx
);
	logic [63:0]   key_mem [SLOT_COUNT];
	logic [63:0]   rd_key_q;
	logic [IW-1:0] rd_idx_q;
	logic [IW:0]   ptr_q;
	logic          rd_vld_q;
	logic          run_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_idx] <= wr_key;
		end
		rd_key_q <= key_mem[ptr_q[IW-1:0]];
		rd_idx_q <= ptr_q[IW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			rd_vld_q <= 1'b0;
			run_q    <= 1'b0;
			done     <= 1'b0;
			found    <= 1'b0;
			hit_idx  <= '0;
		end else begin
			if (go) begin
				run_q    <= 1'b1;
				ptr_q    <= '0;
				rd_vld_q <= 1'b0;
				done     <= 1'b0;
			end else if (run_q) begin
				if (rd_vld_q && in_use[rd_idx_q] && rd_key_q == key) begin
					run_q    <= 1'b0;
					rd_vld_q <= 1'b0;
					done     <= 1'b1;
					found    <= 1'b1;
					hit_idx  <= rd_idx_q;
				end else if (ptr_q == (IW+1)'(SLOT_COUNT)) begin
					// drain the last read before reporting a miss
					rd_vld_q <= 1'b0;
					run_q    <= rd_vld_q;
					done     <= !rd_vld_q;
					found    <= 1'b0;
				end else begin
					rd_vld_q <= 1'b1;
					ptr_q    <= ptr_q + 1'b1;
					done     <= 1'b0;
				end
			end else begin
				rd_vld_q <= 1'b0;
				done     <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

[hdl/lowest_free_slot_allocator_unit.sv]
`default_nettype none
// channel  | ports                          | handshake
// request  | operation, key                 | start high while busy low
// result   | slot, status, used_count       | done strobe, one cycle
// The key search reads one slot a cycle and ends early on a hit in slot k, after
// the last slot on a miss. Link updates follow for create and destroy, a destroy
// adding a backward walk over at most SLOT_COUNT-2 links, then one response
// state; done rises the cycle after. Reset and clear run a pass over all
// SLOT_COUNT links while busy is high. The receiver cannot stall.
module lowest_free_slot_allocator_unit import lfsa_pkg::*; #(
	parameter int SLOT_COUNT = SlotCountDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  operation,
	input  wire logic [63:0] key,
	output logic             done,
	output logic [7:0]       slot,
	output logic [1:0]       status,
	output logic [8:0]       used_count
);
	localparam int IW = $clog2(SLOT_COUNT);
	localparam int LW = IW + 1;
	localparam logic [LW-1:0] END_MARK = LW'(SLOT_COUNT);

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_SEARCH, S_CREATE, S_DEL0, S_DEL1, S_WALK, S_WALKCHK,
		S_FIX0, S_FIX1, S_FIX2, S_RESP
	} state_t;

	state_t             state_q;
	logic [LW-1:0]      link_mem [SLOT_COUNT];
	logic [LW-1:0]      rd_q;
	logic [IW-1:0]      raddr;
	logic               lwe;
	logic [IW-1:0]      lwa;
	logic [LW-1:0]      lwd;
	logic [SLOT_COUNT-1:0] in_use_q;
	logic [LW-1:0]      free_head_q, active_head_q, cnt_q;
	logic [1:0]         op_q;
	logic [63:0]        key_q;
	logic [IW-1:0]      cur_q, p_q, tgt_q;
	logic [LW-1:0]      ncur_q, nprev_q, np_q;
	logic               pact_q, fix_q;
	logic [IW:0]        init_q;
	logic               go, s_done, s_found;
	logic [IW-1:0]      s_idx;
	logic               kwe;

	lfsa_key_search #(.SLOT_COUNT(SLOT_COUNT)) u_search (
		.clk, .arst_n, .go, .key(key_q), .wr_en(kwe), .wr_idx(free_head_q[IW-1:0]),
		.wr_key(key_q), .in_use(in_use_q), .done(s_done), .found(s_found),
		.hit_idx(s_idx)
	);

	always_ff @(posedge clk) begin
		if (lwe) begin
			link_mem[lwa] <= lwd;
		end
		rd_q <= link_mem[raddr];
	end

	assign busy = (state_q != S_IDLE);
	assign kwe  = (state_q == S_CREATE);
	assign go   = (state_q == S_IDLE) && start && (operation != OP_CLEAR);

	// link memory read address per state
	always_comb begin
		case (state_q)
			S_SEARCH: raddr = s_idx;
			S_CREATE: raddr = cur_q;
			S_DEL0:   raddr = cur_q - 1'b1;
			S_WALK:   raddr = p_q - IW'(2);
			default:  raddr = cur_q;
		endcase
	end

	// link memory writes: init pass and the up-to-three pointer updates
	always_comb begin
		lwe = 1'b0;
		lwa = cur_q;
		lwd = '0;
		case (state_q)
			S_INIT: begin
				lwe = 1'b1;
				lwa = init_q[IW-1:0];
				lwd = LW'(init_q) + 1'b1;
			end
			S_FIX0: begin
				lwe = 1'b1;
				lwa = cur_q - 1'b1;
				lwd = nprev_q;
			end
			S_FIX1: begin
				lwe = 1'b1;
				lwa = cur_q;
				lwd = ncur_q;
			end
			S_FIX2: begin
				lwe = fix_q;
				lwa = tgt_q;
				lwd = np_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_INIT;
			init_q        <= '0;
			in_use_q      <= '0;
			free_head_q   <= '0;
			active_head_q <= END_MARK;
			cnt_q         <= '0;
			done          <= 1'b0;
			slot          <= '0;
			status        <= ST_DONE;
			used_count    <= '0;
			op_q <= '0; key_q <= '0; cur_q <= '0; p_q <= '0; tgt_q <= '0;
			ncur_q <= '0; nprev_q <= '0; np_q <= '0; pact_q <= 1'b0; fix_q <= 1'b0;
		end else begin
			done <= (state_q == S_RESP);
			case (state_q)
				S_INIT: begin
					init_q <= init_q + 1'b1;
					if (init_q == (IW+1)'(SLOT_COUNT-1)) begin
						state_q <= op_q == OP_CLEAR ? S_RESP : S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q   <= operation;
						key_q  <= key;
						slot   <= '0;
						status <= ST_DONE;
						if (operation == OP_CLEAR) begin
							in_use_q      <= '0;
							free_head_q   <= '0;
							active_head_q <= END_MARK;
							cnt_q         <= '0;
							init_q        <= '0;
							state_q       <= S_INIT;
						end else begin
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					if (s_done) begin
						if (op_q == OP_CREATE) begin
							if (s_found) begin
								slot    <= 8'(s_idx);
								status  <= ST_MAPPED;
								state_q <= S_RESP;
							end else if (free_head_q == END_MARK) begin
								status  <= ST_FULL;
								state_q <= S_RESP;
							end else begin
								cur_q   <= free_head_q[IW-1:0];
								state_q <= S_CREATE;
							end
						end else if (!s_found) begin
							status  <= ST_MISSING;
							state_q <= S_RESP;
						end else begin
							cur_q  <= s_idx;
							slot   <= 8'(s_idx);
							status <= ST_DONE;
							state_q <= (op_q == OP_DESTROY) ? S_DEL0 : S_RESP;
						end
					end
				end
				S_CREATE: begin
					// read of link[cur] issued this cycle; S_DEL0 sees the data
					state_q <= S_DEL0;
				end
				S_DEL0: begin
					// rd_q = link[cur]; read of link[cur-1] issued
					ncur_q  <= rd_q;
					state_q <= S_DEL1;
				end
				S_DEL1: begin
					// rd_q = link[cur-1] (meaningless when cur is zero)
					slot <= 8'(cur_q);
					fix_q <= 1'b0;
					if (op_q == OP_CREATE) begin
						in_use_q[cur_q] <= 1'b1;
						cnt_q <= cnt_q + 1'b1;
						free_head_q <= ncur_q;
						if (cur_q == '0) begin
							ncur_q  <= active_head_q;
							active_head_q <= '0;
							state_q <= S_FIX1;
						end else begin
							ncur_q  <= rd_q;
							nprev_q <= LW'(cur_q);
							state_q <= S_FIX0;
						end
					end else begin
						in_use_q[cur_q] <= 1'b0;
						if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
						if (cur_q == '0) begin
							active_head_q <= ncur_q;
							ncur_q  <= free_head_q;
							free_head_q <= '0;
							state_q <= S_FIX1;
						end else begin
							pact_q <= (rd_q == LW'(cur_q));
							if (rd_q == LW'(cur_q)) begin
								if (LW'(cur_q) < free_head_q) begin
									nprev_q <= ncur_q;
									ncur_q  <= free_head_q;
									free_head_q <= LW'(cur_q);
									state_q <= S_FIX0;
								end else begin
									nprev_q <= ncur_q;
									p_q     <= cur_q;
									state_q <= S_WALK;
								end
							end else if (LW'(cur_q) == active_head_q) begin
								active_head_q <= ncur_q;
								ncur_q  <= rd_q;
								nprev_q <= LW'(cur_q);
								state_q <= S_FIX0;
							end else begin
								nprev_q <= LW'(cur_q);
								np_q    <= ncur_q;
								ncur_q  <= rd_q;
								p_q     <= cur_q;
								state_q <= S_WALK;
							end
						end
					end
				end
				S_WALK: begin
					// p_q acts as i; candidate p = i-2, stop if below bound
					if (p_q < IW'(2) || LW'(p_q - IW'(2)) <
					    (pact_q ? free_head_q : active_head_q)) begin
						// nothing found: leave links unchanged
						state_q <= S_RESP;
					end else begin
						p_q     <= p_q - 1'b1;
						tgt_q   <= p_q - IW'(2);
						state_q <= S_WALKCHK;
					end
				end
				S_WALKCHK: begin
					// rd_q = link[tgt]
					if (pact_q ? (rd_q > LW'(cur_q)) : (rd_q == LW'(cur_q))) begin
						if (pact_q) begin
							ncur_q <= rd_q;
							np_q   <= LW'(cur_q);
						end
						fix_q   <= 1'b1;
						state_q <= S_FIX0;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_FIX0: state_q <= S_FIX1;
				S_FIX1: state_q <= fix_q ? S_FIX2 : S_RESP;
				S_FIX2: state_q <= S_RESP;
				S_RESP: begin
					used_count <= 9'(cnt_q);
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
